// ===== design/buddy_page_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Wrappers for the concurrent checks of the allocator; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

`define BPA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`define BPA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define BPA_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define BPA_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// pool size; field widths below are sized for it
	localparam int PAGE_COUNT = 1024;

	localparam int ADDR_W = 10;
	localparam int CFG_W  = 11;
	localparam int ORD_W  = 4;
	localparam int STAT_W = 2;

	localparam logic OPER_ALLOC = 1'b0;
	localparam logic OPER_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ORDER = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [4:0] {
		S_BUILD_INIT,
		S_BUILD,
		S_IDLE,
		S_DISPATCH,
		S_ASCAN,
		S_AMARK,
		S_ULINK,
		S_UCLR,
		S_ADESC,
		S_AFIN,
		S_PUSH1,
		S_PUSH2,
		S_FDESC,
		S_FRDL,
		S_FCHK,
		S_FMARK,
		S_FBCHK,
		S_FUP,
		S_DONE
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_BUILD_INIT,
		OP_BUILD_STEP,
		OP_SET_ERR_ORDER,
		OP_SET_ERR_EMPTY,
		OP_ALLOC_CHECK,
		OP_SCAN_STEP,
		OP_ALLOC_TAKE,
		OP_MARK_USED,
		OP_UNLINK_LINK,
		OP_UNLINK_CLR,
		OP_DESCEND,
		OP_ALLOC_RESULT,
		OP_PUSH_HEAD,
		OP_PUSH_LINK,
		OP_FREE_INIT,
		OP_FREE_STEP,
		OP_READ_LEFT,
		OP_LEFT_STEP,
		OP_MARK_FREE,
		OP_MERGE_UNLINK,
		OP_MERGE_UP,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {
		HS_T,
		HS_UL,
		HS_PL
	} head_sel_t;

	typedef struct packed {
		dp_op_t    op;
		head_sel_t head_sel;
		logic      in_take;
	} dp_cmd_t;

	typedef struct packed {
		logic build_last;
		logic o_gt_top;
		logic t_gt_top;
		logic head_empty;
		logic t_eq_o;
		logic ord_zero;
		logic at_addr;
		logic n_root;
		logic addr_oob;
		logic rd_free;
		logic is_free_op;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator
// Binary-tree buddy allocator with per-order LIFO free lists over a page pool.
// ----------------------------------------------------------------------------
//  port group   | handshake           | carries
//  -------------+---------------------+-----------------------------------
//  cfg          | cfg_we              | cfg_wdata: usable page count
//  request      | in_valid / in_ready | operation, order, page_address
//  response     | out_valid/out_ready | status, block_page
//
// One request at a time. Allocate scans the free lists up from the requested
// order, then splits the block one tree level at a time. Free descends the tree
// to the page, probes left children while they are in use, then merges with
// free buddies on the way up. An order error is reported without a walk.
// The rate is set by the single ports of the node flag and link memories.
// After reset and after each cfg write the tree is rebuilt with in_ready low.
// A stalled response sits in the output register and the next request is
// still taken.
`include "buddy_page_allocator_macros.svh"

module buddy_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [bpa_pkg::ORD_W-1:0]     order,
	input  logic [bpa_pkg::ADDR_W-1:0]    page_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bpa_pkg::STAT_W-1:0]    status,
	output logic [bpa_pkg::ADDR_W-1:0]    block_page
);

	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.operation    (operation),
		.order        (order),
		.page_address (page_address),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.block_page   (block_page)
	);

	// a register write starts a rebuild, so no request is taken next cycle
	`BPA_ASSERT_NEXT(a_cfg_rebuild, clk, arst_n, cfg_we, !in_ready)
	// only one request in flight
	`BPA_ASSERT_NEXT(a_one_request, clk, arst_n, in_valid && in_ready, !in_ready)
	// responses with an error status report page zero
	`BPA_ASSERT_IMP(a_err_page, clk, arst_n, out_valid && status != ST_OK, block_page == '0)
	`BPA_ASSERT_IMP(a_status_code, clk, arst_n, out_valid,
		status == ST_OK || status == ST_ORDER || status == ST_EMPTY)

endmodule

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences rebuild, allocate and free steps; drives the datapath by command.
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              in_valid,
	output logic              in_ready,
	input  bpa_pkg::dp_stat_t stat,
	output bpa_pkg::dp_cmd_t  cmd
);

	import bpa_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BUILD_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_BUILD_INIT: state_d = S_BUILD;
			S_BUILD: begin
				if (stat.build_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (stat.is_free_op) begin
					state_d = stat.addr_oob ? S_DONE : S_FDESC;
				end else begin
					state_d = stat.o_gt_top ? S_DONE : S_ASCAN;
				end
			end
			S_ASCAN: begin
				if (stat.t_gt_top) state_d = S_DONE;
				else if (!stat.head_empty) state_d = S_AMARK;
			end
			S_AMARK: state_d = S_ULINK;
			S_ULINK: state_d = S_UCLR;
			S_UCLR: begin
				if (stat.is_free_op) state_d = S_FUP;
				else if (stat.t_eq_o) state_d = S_AFIN;
				else state_d = S_ADESC;
			end
			S_ADESC: state_d = stat.rd_free ? S_PUSH1 : S_AMARK;
			S_AFIN: state_d = S_DONE;
			S_PUSH1: state_d = S_PUSH2;
			S_PUSH2: state_d = stat.is_free_op ? S_DONE : S_AMARK;
			S_FDESC: begin
				if (stat.ord_zero || stat.at_addr) state_d = S_FRDL;
			end
			S_FRDL: state_d = stat.ord_zero ? S_FMARK : S_FCHK;
			S_FCHK: state_d = stat.rd_free ? S_FMARK : S_FRDL;
			S_FMARK: state_d = stat.n_root ? S_PUSH1 : S_FBCHK;
			S_FBCHK: state_d = stat.rd_free ? S_ULINK : S_PUSH1;
			S_FUP: state_d = S_FMARK;
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_BUILD_INIT;
		endcase
		// a register write always restarts the rebuild
		if (cfg_we) state_d = S_BUILD_INIT;
	end

	// outputs
	always_comb begin
		cmd.op       = OP_NONE;
		cmd.head_sel = HS_T;
		cmd.in_take  = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_BUILD_INIT: cmd.op = OP_BUILD_INIT;
			S_BUILD:      cmd.op = OP_BUILD_STEP;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_take = in_valid;
			end
			S_DISPATCH: begin
				if (stat.is_free_op) begin
					cmd.op = stat.addr_oob ? OP_NONE : OP_FREE_INIT;
				end else begin
					cmd.op = stat.o_gt_top ? OP_SET_ERR_ORDER : OP_ALLOC_CHECK;
				end
			end
			S_ASCAN: begin
				if (stat.t_gt_top) cmd.op = OP_SET_ERR_EMPTY;
				else if (stat.head_empty) cmd.op = OP_SCAN_STEP;
				else cmd.op = OP_ALLOC_TAKE;
			end
			S_AMARK: cmd.op = OP_MARK_USED;
			S_ULINK: begin
				cmd.op       = OP_UNLINK_LINK;
				cmd.head_sel = HS_UL;
			end
			S_UCLR:  cmd.op = OP_UNLINK_CLR;
			S_ADESC: cmd.op = OP_DESCEND;
			S_AFIN:  cmd.op = OP_ALLOC_RESULT;
			S_PUSH1: begin
				cmd.op       = OP_PUSH_HEAD;
				cmd.head_sel = HS_PL;
			end
			S_PUSH2: cmd.op = OP_PUSH_LINK;
			S_FDESC: begin
				if (!stat.ord_zero && !stat.at_addr) cmd.op = OP_FREE_STEP;
			end
			S_FRDL: begin
				if (!stat.ord_zero) cmd.op = OP_READ_LEFT;
			end
			S_FCHK: begin
				if (!stat.rd_free) cmd.op = OP_LEFT_STEP;
			end
			S_FMARK: cmd.op = OP_MARK_FREE;
			S_FBCHK: begin
				if (stat.rd_free) cmd.op = OP_MERGE_UNLINK;
			end
			S_FUP: cmd.op = OP_MERGE_UP;
			S_DONE: begin
				if (stat.out_free) cmd.op = OP_EMIT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== design/bpa_dp.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Node flag and link memories, list heads, walk registers and result register.
// ----------------------------------------------------------------------------
module bpa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          operation,
	input  logic [bpa_pkg::ORD_W-1:0]     order,
	input  logic [bpa_pkg::ADDR_W-1:0]    page_address,
	input  bpa_pkg::dp_cmd_t              cmd,
	output bpa_pkg::dp_stat_t             stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bpa_pkg::STAT_W-1:0]    status,
	output logic [bpa_pkg::ADDR_W-1:0]    block_page
);

	import bpa_pkg::*;

	// pool is a power of two; tree in heap order, root has the top order
	localparam int ORDER_LEVELS = $clog2(PAGE_COUNT) + 1;
	localparam int ROOT         = ORDER_LEVELS - 1;
	localparam int NODE_COUNT   = 2 * PAGE_COUNT - 1;
	localparam int NW  = $clog2(2 * PAGE_COUNT);
	localparam int LW  = NW + 1;
	localparam int OW  = $clog2(ORDER_LEVELS + 1);
	localparam int HW  = $clog2(ORDER_LEVELS);
	localparam int PW  = $clog2(PAGE_COUNT + 1);
	localparam int SW  = PW + 1;
	localparam int XW  = (OW > ORD_W) ? OW : ORD_W;
	localparam int AXW = (PW > ADDR_W) ? PW : ADDR_W;
	localparam int CXW = (PW > CFG_W) ? PW : CFG_W;
	localparam logic [LW-1:0] EMPTY = {LW{1'b1}};

	// configuration and list state
	logic [PW-1:0] usable_q;
	logic [OW-1:0] top_q;
	logic [LW-1:0] head_q [ORDER_LEVELS];

	// walk registers
	logic              op_q;
	logic [ORD_W-1:0]  o_q;
	logic [ADDR_W-1:0] a_q;
	logic [NW-1:0]     n_q;
	logic [OW-1:0]     t_q;
	logic [PW-1:0]     s_q;
	logic [NW-1:0]     u_q;
	logic [OW-1:0]     ul_q;
	logic [NW-1:0]     pn_q;
	logic [OW-1:0]     pl_q;
	logic [LW-1:0]     h_q;
	logic [NW-1:0]     bi_q;
	logic [OW-1:0]     bd_q;
	logic [NW-1:0]     bk_q;
	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_page_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] block_page_q;

	// memory ports
	logic          fr_we, fr_re, fr_wdata, fr_rdata;
	logic [NW-1:0] fr_waddr, fr_raddr;
	logic          nx_we, pv_we, lk_re;
	logic [NW-1:0] nx_waddr, pv_waddr, lk_raddr;
	logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

	// derived values
	logic [NW-1:0]     left_n, right_n, parent_n, buddy_n;
	logic [OW-1:0]     hidx;
	logic [LW-1:0]     hrd;
	logic [CXW-1:0]    cfg_clamped;
	logic [OW-1:0]     top_new;
	logic [LW-1:0]     head_new [ORDER_LEVELS];
	logic [SW-1:0]     b_start, b_size;
	logic              b_free, bk_last;
	logic [PW-1:0]     rs_page;
	logic [OW-1:0]     d_alloc;
	logic [LW-1:0]     kk, sp;

	assign left_n   = {n_q[NW-2:0], 1'b1};
	assign right_n  = {n_q[NW-2:0] + (NW-1)'(1), 1'b0};
	assign parent_n = (n_q - NW'(1)) >> 1;
	assign buddy_n  = n_q[0] ? n_q + NW'(1) : n_q - NW'(1);

	always_comb begin
		case (cmd.head_sel)
			HS_UL:   hidx = ul_q;
			HS_PL:   hidx = pl_q;
			default: hidx = t_q;
		endcase
	end
	assign hrd = head_q[hidx[HW-1:0]];

	// clamp the written page count to 1..PAGE_COUNT
	always_comb begin
		if (cfg_wdata == '0) cfg_clamped = CXW'(1);
		else if (CXW'(cfg_wdata) > CXW'(PAGE_COUNT)) cfg_clamped = CXW'(PAGE_COUNT);
		else cfg_clamped = CXW'(cfg_wdata);
	end

	// rebuild values: top order and the one partial-tree head per order
	always_comb begin
		top_new = '0;
		for (int i = 1; i <= ROOT; i++) begin
			if ((usable_q >> i) != '0) top_new = OW'(i);
		end
		for (int o = 0; o < ROOT; o++) begin
			if (usable_q[o]) begin
				head_new[o] = LW'((NW'(1) << (ROOT - o)) - NW'(1)
					+ NW'((usable_q >> (o + 1)) << 1));
			end else begin
				head_new[o] = EMPTY;
			end
		end
		head_new[ROOT] = (usable_q == PW'(PAGE_COUNT)) ? '0 : EMPTY;
	end

	// a node is free when its whole span lies below the usable count
	assign b_size  = SW'(1) << (OW'(ROOT) - bd_q);
	assign b_start = SW'(bk_q) << (OW'(ROOT) - bd_q);
	assign b_free  = (b_start + b_size) <= SW'(usable_q);
	assign bk_last = bk_q == ((NW'(1) << bd_q) - NW'(1));

	assign rs_page = s_q + (PW'(1) << (t_q - OW'(1)));

	assign d_alloc = OW'(ROOT) - t_q;
	assign kk      = LW'(n_q) + LW'(1) - (LW'(1) << d_alloc);
	assign sp      = kk << t_q;

	// memory port selection
	always_comb begin
		fr_we = 1'b0; fr_waddr = n_q; fr_wdata = 1'b0;
		fr_re = 1'b0; fr_raddr = right_n;
		nx_we = 1'b0; nx_waddr = u_q; nx_wdata = EMPTY;
		pv_we = 1'b0; pv_waddr = u_q; pv_wdata = EMPTY;
		lk_re = 1'b0; lk_raddr = n_q;
		case (cmd.op)
			OP_BUILD_STEP: begin
				fr_we = 1'b1; fr_waddr = bi_q; fr_wdata = b_free;
				nx_we = 1'b1; nx_waddr = bi_q;
				pv_we = 1'b1; pv_waddr = bi_q;
			end
			OP_MARK_USED: begin
				fr_we = 1'b1;
				lk_re = 1'b1;
			end
			OP_UNLINK_LINK: begin
				fr_re    = 1'b1;
				nx_we    = ~pv_rdata[NW];
				nx_waddr = pv_rdata[NW-1:0];
				nx_wdata = nx_rdata;
				pv_we    = ~nx_rdata[NW];
				pv_waddr = nx_rdata[NW-1:0];
				pv_wdata = pv_rdata;
			end
			OP_UNLINK_CLR: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			OP_PUSH_HEAD: begin
				nx_we = 1'b1; nx_waddr = pn_q; nx_wdata = hrd;
				pv_we = 1'b1; pv_waddr = pn_q;
			end
			OP_PUSH_LINK: begin
				pv_we    = ~h_q[NW];
				pv_waddr = h_q[NW-1:0];
				pv_wdata = LW'(pn_q);
			end
			OP_READ_LEFT: begin
				fr_re = 1'b1; fr_raddr = left_n;
			end
			OP_MARK_FREE: begin
				fr_we = 1'b1; fr_wdata = 1'b1;
				fr_re = 1'b1; fr_raddr = buddy_n;
			end
			OP_MERGE_UNLINK: begin
				lk_re = 1'b1; lk_raddr = buddy_n;
			end
			default: ;
		endcase
	end

	bpa_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_free_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (nx_rdata)
	);

	bpa_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (pv_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q    <= PW'(PAGE_COUNT);
			top_q       <= OW'(ROOT);
			out_valid_q <= 1'b0;
			for (int i = 0; i < ORDER_LEVELS; i++) head_q[i] <= EMPTY;
		end else begin
			if (cfg_we) usable_q <= PW'(cfg_clamped);
			case (cmd.op)
				OP_BUILD_INIT: begin
					top_q <= top_new;
					for (int i = 0; i < ORDER_LEVELS; i++) head_q[i] <= head_new[i];
				end
				OP_UNLINK_LINK: begin
					if (hrd == LW'(u_q)) head_q[hidx[HW-1:0]] <= nx_rdata;
				end
				OP_PUSH_HEAD: head_q[hidx[HW-1:0]] <= LW'(pn_q);
				default: ;
			endcase
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			op_q         <= operation;
			o_q          <= order;
			a_q          <= page_address;
			res_status_q <= ST_OK;
			res_page_q   <= '0;
		end
		case (cmd.op)
			OP_BUILD_INIT: begin
				bi_q <= '0;
				bd_q <= '0;
				bk_q <= '0;
			end
			OP_BUILD_STEP: begin
				bi_q <= bi_q + NW'(1);
				if (bk_last) begin
					bd_q <= bd_q + OW'(1);
					bk_q <= '0;
				end else begin
					bk_q <= bk_q + NW'(1);
				end
			end
			OP_SET_ERR_ORDER: res_status_q <= ST_ORDER;
			OP_SET_ERR_EMPTY: res_status_q <= ST_EMPTY;
			OP_ALLOC_CHECK:   t_q <= OW'(o_q);
			OP_SCAN_STEP:     t_q <= t_q + OW'(1);
			OP_ALLOC_TAKE:    n_q <= hrd[NW-1:0];
			OP_MARK_USED: begin
				u_q  <= n_q;
				ul_q <= t_q;
			end
			OP_DESCEND: begin
				pn_q <= right_n;
				pl_q <= t_q - OW'(1);
				n_q  <= left_n;
				t_q  <= t_q - OW'(1);
			end
			OP_ALLOC_RESULT: res_page_q <= ADDR_W'(sp);
			OP_PUSH_HEAD:    h_q <= hrd;
			OP_FREE_INIT: begin
				n_q <= '0;
				t_q <= OW'(ROOT);
				s_q <= '0;
			end
			OP_FREE_STEP: begin
				if (AXW'(a_q) < AXW'(rs_page)) begin
					n_q <= left_n;
				end else begin
					n_q <= right_n;
					s_q <= rs_page;
				end
				t_q <= t_q - OW'(1);
			end
			OP_LEFT_STEP: begin
				n_q <= left_n;
				t_q <= t_q - OW'(1);
			end
			OP_MARK_FREE: begin
				pn_q <= n_q;
				pl_q <= t_q;
			end
			OP_MERGE_UNLINK: begin
				u_q  <= buddy_n;
				ul_q <= t_q;
			end
			OP_MERGE_UP: begin
				n_q <= parent_n;
				t_q <= t_q + OW'(1);
			end
			OP_EMIT: begin
				status_q     <= res_status_q;
				block_page_q <= res_page_q;
			end
			default: ;
		endcase
	end

	assign stat.build_last = bi_q == NW'(NODE_COUNT - 1);
	assign stat.o_gt_top   = XW'(o_q) > XW'(top_q);
	assign stat.t_gt_top   = t_q > top_q;
	assign stat.head_empty = hrd[NW];
	assign stat.t_eq_o     = XW'(t_q) == XW'(o_q);
	assign stat.ord_zero   = t_q == '0;
	assign stat.at_addr    = AXW'(s_q) == AXW'(a_q);
	assign stat.n_root     = n_q == '0;
	assign stat.addr_oob   = AXW'(a_q) >= AXW'(PAGE_COUNT);
	assign stat.rd_free    = fr_rdata;
	assign stat.is_free_op = op_q == OPER_FREE;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign block_page = block_page_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Checks allocate and free responses against a cycle-free tree model held in
// the bench. Covers directed corner cases, pool size changes and random
// traffic, with idle bursts and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

	import bpa_pkg::*;

	localparam int PAGES  = 1024;
	localparam int LEVELS = 11;
	localparam int NODES  = 2 * PAGES - 1;
	localparam int ROOT   = LEVELS - 1;
	localparam int NONE   = -1;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] page;
	} alloc_reply_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic [ORD_W-1:0]    order;
	logic [ADDR_W-1:0]   page_address;
	logic                out_valid;
	logic                out_ready;
	logic [STAT_W-1:0]   status;
	logic [ADDR_W-1:0]   block_page;

	// tree model
	bit node_avail[NODES];
	int link_next[NODES];
	int link_prev[NODES];
	int free_head[LEVELS];
	int top_ord;

	alloc_reply_t      pending_q[$];
	int                held_pages[$];
	int                mismatches;
	int                replies_seen;
	int                requests_sent;
	int                allocs_ok;
	int                frees_sent;
	int                idle_cycles;
	bit                gaps_on;
	int                hold_cnt;
	bit                long_hold_req;

	buddy_page_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.order        (order),
		.page_address (page_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.block_page   (block_page)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit in_tree(int n);
		return n >= 0 && n < NODES;
	endfunction

	function automatic bit avail(int n);
		return in_tree(n) && node_avail[n];
	endfunction

	function automatic int node_depth(int n);
		int d;
		int m;
		d = 0;
		m = n + 1;
		while (m > 1) begin
			m = m >> 1;
			d++;
		end
		return d;
	endfunction

	function automatic int first_page(int n);
		int d;
		if (!in_tree(n))
			return 0;
		d = node_depth(n);
		return (n + 1 - (1 << d)) << (ROOT - d);
	endfunction

	function automatic void list_remove(int n, int lvl);
		int p;
		int x;
		if (!in_tree(n))
			return;
		p = link_prev[n];
		x = link_next[n];
		if (in_tree(p))
			link_next[p] = x;
		if (in_tree(x))
			link_prev[x] = p;
		if (lvl >= 0 && lvl < LEVELS && free_head[lvl] == n)
			free_head[lvl] = x;
		link_next[n] = NONE;
		link_prev[n] = NONE;
	endfunction

	function automatic void list_push(int n, int lvl);
		int h;
		if (!in_tree(n) || lvl < 0 || lvl >= LEVELS)
			return;
		h = free_head[lvl];
		link_next[n] = h;
		link_prev[n] = NONE;
		if (in_tree(h))
			link_prev[h] = n;
		free_head[lvl] = n;
	endfunction

	function automatic void build_tree(int usable);
		int l;
		int r;
		top_ord = 0;
		for (int i = 0; i < NODES; i++) begin
			link_next[i] = NONE;
			link_prev[i] = NONE;
		end
		for (int i = 0; i < LEVELS; i++)
			free_head[i] = NONE;
		while (top_ord + 1 < LEVELS && (usable >> (top_ord + 1)) != 0)
			top_ord++;
		for (int i = 0; i < PAGES; i++)
			node_avail[PAGES - 1 + i] = (i < usable);
		for (int n = PAGES - 2; n >= 0; n--) begin
			l = 2 * n + 1;
			r = 2 * n + 2;
			node_avail[n] = node_avail[l] && node_avail[r];
			if (node_avail[l] && !node_avail[r])
				free_head[ROOT - node_depth(l)] = l;
		end
		if (node_avail[0])
			free_head[ROOT] = 0;
	endfunction

	function automatic alloc_reply_t take_block(int ord);
		alloc_reply_t res;
		int t;
		int n;
		res.status = ST_OK;
		res.page = '0;
		if (ord > top_ord) begin
			res.status = ST_ORDER;
			return res;
		end
		t = ord;
		while (t <= top_ord && !in_tree(free_head[t]))
			t++;
		if (t > top_ord) begin
			res.status = ST_EMPTY;
			return res;
		end
		n = free_head[t];
		while (t != ord) begin
			node_avail[n] = 1'b0;
			list_remove(n, t);
			if (avail(2 * n + 2))
				list_push(2 * n + 2, t - 1);
			n = 2 * n + 1;
			t--;
		end
		node_avail[n] = 1'b0;
		list_remove(n, t);
		res.page = ADDR_W'(first_page(n));
		return res;
	endfunction

	function automatic void return_block(int a);
		int n;
		int ord;
		int b;
		n = 0;
		ord = ROOT;
		while (ord > 0 && first_page(n) != a) begin
			n = (a < first_page(2 * n + 2)) ? 2 * n + 1 : 2 * n + 2;
			ord--;
		end
		// go further down the left edge while that child is in use
		while (ord > 0 && !avail(2 * n + 1)) begin
			n = 2 * n + 1;
			ord--;
		end
		if (in_tree(n))
			node_avail[n] = 1'b1;
		while (n != 0 && in_tree(n)) begin
			b = (n & 1) ? n + 1 : n - 1;
			if (!avail(b))
				break;
			list_remove(b, ord);
			n = (n - 1) / 2;
			node_avail[n] = 1'b1;
			ord++;
		end
		list_push(n, ord);
	endfunction

	// sends one request and queues its expected reply on the transfer
	task automatic send_request(logic op, logic [ORD_W-1:0] ord, logic [ADDR_W-1:0] addr);
		alloc_reply_t res;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		order        <= ord;
		page_address <= addr;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		if (op == OPER_ALLOC) begin
			res = take_block(ord);
			if (res.status == ST_OK) begin
				held_pages.push_back(res.page);
				allocs_ok++;
			end
		end else begin
			return_block(addr);
			res.status = ST_OK;
			res.page = '0;
			frees_sent++;
			foreach (held_pages[i])
				if (held_pages[i] == addr) begin
					held_pages.delete(i);
					break;
				end
		end
		pending_q.push_back(res);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_pool_size(int value);
		int eff;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		eff = (value < 1) ? 1 : (value > PAGES) ? PAGES : value;
		build_tree(eff);
	endtask

	task automatic free_held();
		int idx;
		int pg;
		idx = $urandom_range(0, held_pages.size() - 1);
		pg = held_pages[idx];
		send_request(OPER_FREE, '0, ADDR_W'(pg));
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55 || (r < 92 && held_pages.size() == 0)) begin
			if ($urandom_range(0, 9) == 0)
				send_request(OPER_ALLOC, ORD_W'($urandom_range(0, 15)), ADDR_W'($urandom));
			else
				send_request(OPER_ALLOC, ORD_W'($urandom_range(0, 3)), ADDR_W'($urandom));
		end else if (r < 92)
			free_held();
		else
			send_request(OPER_FREE, ORD_W'($urandom), ADDR_W'($urandom));
	endtask

	task automatic test_full_pool();
		send_request(OPER_ALLOC, 4'd15, '0);
		send_request(OPER_ALLOC, 4'd11, '0);
		send_request(OPER_ALLOC, 4'd10, '0);
		send_request(OPER_ALLOC, 4'd0, '0);
		send_request(OPER_FREE, 4'd0, 10'd0);
		send_request(OPER_ALLOC, 4'd0, '0);
		send_request(OPER_ALLOC, 4'd3, '0);
		send_request(OPER_ALLOC, 4'd9, '0);
		send_request(OPER_FREE, 4'd15, 10'd1023);
		send_request(OPER_FREE, 4'd0, 10'd8);
		send_request(OPER_FREE, 4'd0, 10'd0);
		send_request(OPER_FREE, 4'd0, 10'd512);
		send_request(OPER_ALLOC, 4'd10, '0);
		send_request(OPER_FREE, 4'd0, 10'd0);
	endtask

	task automatic test_pool_extremes();
		// zero clamps to one page
		set_pool_size(0);
		send_request(OPER_ALLOC, 4'd1, '0);
		send_request(OPER_ALLOC, 4'd0, '0);
		send_request(OPER_ALLOC, 4'd0, '0);
		send_request(OPER_FREE, 4'd0, 10'd0);
		set_pool_size(1000);
		send_request(OPER_ALLOC, 4'd9, '0);
		send_request(OPER_ALLOC, 4'd9, '0);
		send_request(OPER_ALLOC, 4'd10, '0);
		send_request(OPER_FREE, 4'd0, 10'd1020);
		set_pool_size(2047);
		send_request(OPER_ALLOC, 4'd10, '0);
		send_request(OPER_FREE, 4'd0, 10'd0);
	endtask

	task automatic test_random(int pool, int count, bit gaps);
		set_pool_size(pool);
		held_pages.delete();
		gaps_on = gaps;
		repeat (count) send_random();
	endtask

	task automatic test_back_pressure();
		wait_drained();
		gaps_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (12) send_request(OPER_ALLOC, ORD_W'($urandom_range(0, 2)), '0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = OPER_ALLOC;
		order = '0;
		page_address = '0;
		mismatches = 0;
		replies_seen = 0;
		requests_sent = 0;
		allocs_ok = 0;
		frees_sent = 0;
		gaps_on = 1'b1;
		long_hold_req = 1'b0;
		build_tree(PAGES);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_full_pool();
		test_pool_extremes();
		test_random(PAGES, 500, 1'b1);
		test_random($urandom_range(1, 2047), 350, 1'b1);
		test_back_pressure();
		test_random(700, 350, 1'b1);
		test_random(1, 50, 1'b1);
		test_random(PAGES, 500, 1'b0);
		wait_drained();
		$display("covered %0d requests: %0d allocations granted, %0d frees, %0d replies",
			requests_sent, allocs_ok, frees_sent, replies_seen);
		$display("pool sizes 1, 1000, 700, 1024, clamped and random, with stalls both sides");
		if (mismatches == 0)
			$display("buddy_page_allocator test passed");
		else
			$display("buddy_page_allocator test failed");
		$finish;
	end

	// response side ready, with random stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt  <= 0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_cnt  <= 400;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			hold_cnt  <= $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			replies_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: status %0d page %0d", status, block_page);
			end else begin
				want = pending_q.pop_front();
				if (status !== want.status || block_page !== want.page) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply mismatch: expected status %0d page %0d, got %0d %0d",
							want.status, want.page, status, block_page);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("buddy_page_allocator test failed");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

// ===== buddy_page_allocator.f =====
+incdir+design
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_ctrl.sv
design/bpa_dp.sv
design/buddy_page_allocator.sv
tb/testbench.sv
